@@ hdl/wia_pkg.sv @@
// wia_pkg: shared constants, register codes, state encodings and control structs
// for the waveform interval averager. No dependencies.
package wia_pkg;

    localparam int SAMPLE_W    = 16;    // raw converter sample
    localparam int VALUE_W     = 48;    // Q32.16 result voltage
    localparam int GAIN_W      = 32;    // volts per count, 2^-32 V units
    localparam int OFFSET_W    = 32;    // Q16.16 vertical origin
    localparam int GAIN_FRAC_W = 16;    // product >> 16 gives Q32.16
    localparam int CFG_IDX_W   = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 2'd0,
        REG_STEP   = 2'd1,
        REG_GAIN   = 2'd2,
        REG_OFFSET = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_MUL  = 4'b0010,
        SC_DIV  = 4'b0100,
        SC_FIN  = 4'b1000
    } scale_state_t;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_START   = 4'b0010,
        ST_RUN     = 4'b0100,
        ST_DELIVER = 4'b1000
    } ctrl_state_t;

    // which of the two possible results one sample raises
    typedef struct packed {
        logic valid0;
        logic valid1;
        logic last;
    } job_ctrl_t;

endpackage

@@ hdl/wia_scale.sv @@
// wia_scale: bit-serial scaling unit, value = +-((|sum| * gain) >> 16) / count + offset.
// Shift-add multiply one gain bit per cycle, restoring divide one quotient bit per cycle.
// Depends on wia_pkg.
module wia_scale #(
    parameter int SUM_W = 36,
    parameter int CNT_W = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [SUM_W-1:0]              sum,
    input  logic [CNT_W-1:0]              count,
    input  logic [wia_pkg::GAIN_W-1:0]    gain,
    input  logic [wia_pkg::OFFSET_W-1:0]  offset,
    output logic                          done,
    output logic [wia_pkg::VALUE_W-1:0]   value
);
    import wia_pkg::*;

    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int P_W    = PROD_W - GAIN_FRAC_W;
    localparam int STEP_W = $clog2(P_W + 1);

    scale_state_t         state_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [SUM_W-1:0]     mag_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [P_W-1:0]       quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     div_reg;
    logic [VALUE_W-1:0]   value_reg;

    logic [SUM_W:0]       add_sum;
    logic [PROD_W-1:0]    acc_next;
    logic [CNT_W:0]       trial;
    logic [CNT_W:0]       diff;
    logic                 fits;
    logic [VALUE_W-1:0]   quo_ext;
    logic [VALUE_W-1:0]   off_ext;
    logic [VALUE_W-1:0]   value_next;

    // one shift-add step: add magnitude into the top, shift right one
    assign add_sum  = {1'b0, acc_reg[PROD_W-1:GAIN_W]}
                    + (gain_reg[0] ? {1'b0, mag_reg} : '0);
    assign acc_next = {add_sum, acc_reg[GAIN_W-1:1]};

    // one restoring divide step, next dividend bit from quotient msb
    assign trial = {rem_reg, quo_reg[P_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    assign quo_ext    = VALUE_W'(quo_reg);
    assign off_ext    = {{(VALUE_W-OFFSET_W){offset[OFFSET_W-1]}}, offset};
    assign value_next = off_ext + (neg_reg ? (~quo_ext + 1'b1) : quo_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SC_IDLE:
                begin
                    if (start)
                    begin
                        step_reg  <= STEP_W'(GAIN_W - 1);
                        state_reg <= SC_MUL;
                    end
                end
                SC_MUL:
                begin
                    if (step_reg == '0)
                    begin
                        step_reg  <= STEP_W'(P_W - 1);
                        state_reg <= (div_reg > CNT_W'(1)) ? SC_DIV : SC_FIN;
                    end
                    else
                    begin
                        step_reg <= step_reg - 1'b1;
                    end
                end
                SC_DIV:
                begin
                    if (step_reg == '0)
                        state_reg <= SC_FIN;
                    else
                        step_reg <= step_reg - 1'b1;
                end
                SC_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= SC_IDLE;
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= sum[SUM_W-1];
                    mag_reg  <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
                    gain_reg <= gain;
                    acc_reg  <= '0;
                    div_reg  <= count;
                end
            end
            SC_MUL:
            begin
                acc_reg  <= acc_next;
                gain_reg <= gain_reg >> 1;
                rem_reg  <= '0;
                if (step_reg == '0)
                begin
                    // zero count reads as a zero quotient
                    if (div_reg == '0)
                        quo_reg <= '0;
                    else
                        quo_reg <= acc_next[PROD_W-1:GAIN_FRAC_W];
                end
            end
            SC_DIV:
            begin
                rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_reg <= {quo_reg[P_W-2:0], fits};
            end
            SC_FIN:
            begin
                value_reg <= value_next;
            end
            default:
            begin
                value_reg <= value_reg;
            end
        endcase
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

@@ hdl/wia_tracker.sv @@
// wia_tracker: sample counter, phase accumulator and open-bin state; decides which
// results one sample raises and what they carry. Depends on wia_pkg.
module wia_tracker #(
    parameter int INDEX_BITS     = 20,
    parameter int STEP_FRAC_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [wia_pkg::SAMPLE_W-1:0]         sample,
    input  logic                                 last,
    input  logic                                 mode,
    input  logic [STEP_FRAC_BITS:0]              step,
    output wia_pkg::job_ctrl_t                   job_ctrl,
    output logic [INDEX_BITS-1:0]                job0_bin,
    output logic [INDEX_BITS+wia_pkg::SAMPLE_W-1:0] job0_sum,
    output logic [INDEX_BITS:0]                  job0_count,
    output logic [INDEX_BITS-1:0]                job0_first,
    output logic [INDEX_BITS-1:0]                job0_end,
    output logic [INDEX_BITS-1:0]                job1_bin,
    output logic [INDEX_BITS+wia_pkg::SAMPLE_W-1:0] job1_sum,
    output logic [INDEX_BITS:0]                  job1_count,
    output logic [INDEX_BITS-1:0]                job1_first,
    output logic [INDEX_BITS-1:0]                job1_end
);
    import wia_pkg::*;

    localparam int IB    = INDEX_BITS;
    localparam int SF    = STEP_FRAC_BITS;
    localparam int PH_W  = IB + SF;
    localparam int SUM_W = IB + SAMPLE_W;
    localparam int CNT_W = IB + 1;

    logic [IB-1:0]    cnt_reg;
    logic [PH_W-1:0]  phase_reg;
    logic [IB-1:0]    cur_bin_reg;
    logic [IB-1:0]    start_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;

    logic [IB-1:0]    bin;
    logic [IB-1:0]    abin;
    logic             on_edge;
    logic             changed;
    logic [SUM_W-1:0] sx;
    logic [IB-1:0]    upd_bin;
    logic [IB-1:0]    upd_start;
    logic [SUM_W-1:0] upd_sum;
    logic [CNT_W-1:0] upd_count;

    assign bin     = phase_reg[PH_W-1:SF];
    assign on_edge = (phase_reg[SF-1:0] == '0);
    // final sample exactly on a boundary closes out the previous bin
    assign abin    = (last && on_edge && (bin != '0)) ? bin - 1'b1 : bin;
    assign changed = (abin != cur_bin_reg);
    assign sx      = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

    assign upd_bin   = changed ? abin : cur_bin_reg;
    assign upd_start = changed ? cnt_reg : start_reg;
    assign upd_sum   = changed ? sx : sum_reg + sx;
    assign upd_count = changed ? CNT_W'(1) : count_reg + 1'b1;

    always_comb
    begin
        job_ctrl.last   = last;
        job_ctrl.valid1 = last && (!mode || !on_edge);
        if (!mode)
        begin
            // averaging: closed bin goes out
            job_ctrl.valid0 = changed;
            job0_bin        = cur_bin_reg;
            job0_sum        = sum_reg;
            job0_count      = count_reg;
            job0_first      = start_reg;
            job0_end        = cnt_reg - 1'b1;
            job1_bin        = upd_bin;
            job1_sum        = upd_sum;
            job1_count      = upd_count;
            job1_first      = upd_start;
            job1_end        = cnt_reg;
        end
        else
        begin
            // points: first sample of each bin, plus trailing extra point
            job_ctrl.valid0 = (cnt_reg == '0) || (bin != cur_bin_reg);
            job0_bin        = bin;
            job0_sum        = sx;
            job0_count      = CNT_W'(1);
            job0_first      = cnt_reg;
            job0_end        = cnt_reg;
            job1_bin        = bin + 1'b1;
            job1_sum        = sx;
            job1_count      = CNT_W'(1);
            job1_first      = cnt_reg;
            job1_end        = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            phase_reg   <= '0;
            cur_bin_reg <= '0;
            start_reg   <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                cnt_reg     <= '0;
                phase_reg   <= '0;
                cur_bin_reg <= '0;
                start_reg   <= '0;
                sum_reg     <= '0;
                count_reg   <= '0;
            end
            else
            begin
                cnt_reg     <= cnt_reg + 1'b1;
                phase_reg   <= phase_reg + PH_W'(step);
                cur_bin_reg <= upd_bin;
                start_reg   <= upd_start;
                sum_reg     <= upd_sum;
                count_reg   <= upd_count;
            end
        end
    end

endmodule

@@ hdl/waveform_interval_averager_unit.sv @@
// waveform_interval_averager_unit: top level of the boxcar average decimator.
// Holds config registers, result sequencer and output register; uses wia_pkg,
// wia_tracker and wia_scale.
//
// Usage:
//  - s_* channel: one signed sample per request; s_tlast marks the final sample
//    of the waveform and clears all bin state after it is processed.
//  - m_* channel: one result per request. m_tuser is set on the last result a
//    sample raises, m_tlast on the last result of the waveform.
//  - cfg_* channel: register writes, always ready; write only while idle.
//  - Each sample raises zero, one or two results. Each result is scaled by a
//    bit-serial unit: a shift-add multiply, then a restoring divide when the
//    bin holds more than one sample, then a handoff to the output register.
//    Points-mode results skip the divide; a sample that raises no result
//    leaves s_tready high.
//  - The multiply/divide unit is the throughput limit; one sample is in work
//    at a time, s_tready drops until all its results sit in the output register.
//  - The output register holds a result while m_tready is low; the sequencer
//    keeps working the next result and stalls only when it must hand it over.
//  - Reset: config returns to averaging mode, step of one, gain 65536, offset
//    0; bin state and output valid clear.
module waveform_interval_averager_unit #(
    parameter  int INDEX_BITS     = 20,
    parameter  int STEP_FRAC_BITS = 24,
    localparam int M_DATA_W = ((3 * INDEX_BITS + wia_pkg::VALUE_W + 7) / 8) * 8,
    localparam int CFG_W    = (STEP_FRAC_BITS + 1 > 32) ? STEP_FRAC_BITS + 1 : 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample [15:0]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wia_pkg::SAMPLE_W-1:0]    s_tdata,
    input  logic                            s_tlast,    // end_of_wave
    // bin_index, value, first_index, end_index (lowest bits first), zero padded
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [M_DATA_W-1:0]             m_tdata,
    output logic                            m_tuser,    // final_result
    output logic                            m_tlast,    // wave_done
    // register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wia_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]                cfg_data
);
    import wia_pkg::*;

    localparam int IB    = INDEX_BITS;
    localparam int SF    = STEP_FRAC_BITS;
    localparam int SUM_W = IB + SAMPLE_W;
    localparam int CNT_W = IB + 1;

    // configuration
    logic                 mode_reg;
    logic [SF:0]          step_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic [OFFSET_W-1:0]  offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            step_reg   <= {1'b1, {SF{1'b0}}};
            gain_reg   <= GAIN_RESET;
            offset_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[0];
                REG_STEP:   step_reg   <= cfg_data[SF:0];
                REG_GAIN:   gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_OFFSET: offset_reg <= cfg_data[OFFSET_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // bin tracking
    ctrl_state_t          state_reg;
    logic                 s_accept;
    job_ctrl_t            jc;
    logic [IB-1:0]        t0_bin,   t1_bin;
    logic [SUM_W-1:0]     t0_sum,   t1_sum;
    logic [CNT_W-1:0]     t0_count, t1_count;
    logic [IB-1:0]        t0_first, t1_first;
    logic [IB-1:0]        t0_end,   t1_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    wia_tracker #(
        .INDEX_BITS     (IB),
        .STEP_FRAC_BITS (SF)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (s_accept),
        .sample     (s_tdata),
        .last       (s_tlast),
        .mode       (mode_reg),
        .step       (step_reg),
        .job_ctrl   (jc),
        .job0_bin   (t0_bin),
        .job0_sum   (t0_sum),
        .job0_count (t0_count),
        .job0_first (t0_first),
        .job0_end   (t0_end),
        .job1_bin   (t1_bin),
        .job1_sum   (t1_sum),
        .job1_count (t1_count),
        .job1_first (t1_first),
        .job1_end   (t1_end)
    );

    // pending results of the sample in work
    job_ctrl_t            job_reg;
    logic [IB-1:0]        j0_bin_reg,   j1_bin_reg;
    logic [SUM_W-1:0]     j0_sum_reg,   j1_sum_reg;
    logic [CNT_W-1:0]     j0_count_reg, j1_count_reg;
    logic [IB-1:0]        j0_first_reg, j1_first_reg;
    logic [IB-1:0]        j0_end_reg,   j1_end_reg;

    logic                 sel;        // 0: first result, 1: second
    logic                 sc_done;
    logic [VALUE_W-1:0]   sc_value;
    logic                 out_free;
    logic                 deliver;
    logic                 is_final;

    assign sel      = !job_reg.valid0;
    assign out_free = !m_tvalid || m_tready;
    assign deliver  = (state_reg == ST_DELIVER) && out_free;
    assign is_final = sel || !job_reg.valid1;

    wia_scale #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == ST_START),
        .sum    (sel ? j1_sum_reg : j0_sum_reg),
        .count  (sel ? j1_count_reg : j0_count_reg),
        .gain   (gain_reg),
        .offset (offset_reg),
        .done   (sc_done),
        .value  (sc_value)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        job_reg <= jc;
                        if (jc.valid0 || jc.valid1)
                            state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    if (sc_done)
                        state_reg <= ST_DELIVER;
                end
                ST_DELIVER:
                begin
                    if (out_free)
                    begin
                        if (!sel)
                        begin
                            job_reg.valid0 <= 1'b0;
                            state_reg      <= job_reg.valid1 ? ST_START : ST_IDLE;
                        end
                        else
                        begin
                            job_reg.valid1 <= 1'b0;
                            state_reg      <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            j0_bin_reg   <= t0_bin;
            j0_sum_reg   <= t0_sum;
            j0_count_reg <= t0_count;
            j0_first_reg <= t0_first;
            j0_end_reg   <= t0_end;
            j1_bin_reg   <= t1_bin;
            j1_sum_reg   <= t1_sum;
            j1_count_reg <= t1_count;
            j1_first_reg <= t1_first;
            j1_end_reg   <= t1_end;
        end
    end

    // output register
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (deliver)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            m_tdata_reg <= sel
                ? M_DATA_W'({j1_end_reg, j1_first_reg, sc_value, j1_bin_reg})
                : M_DATA_W'({j0_end_reg, j0_first_reg, sc_value, j0_bin_reg});
            m_tuser_reg <= is_final;
            m_tlast_reg <= is_final && job_reg.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hdl/wia_checker.sv @@
// wia_checker: port-level assertions for waveform_interval_averager_unit, attached
// by the bind below. Depends on the top level's port list only.
module wia_checker #(
    parameter int DATA_W = 112
) (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tuser,
    input logic              m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output result changed while stalled");

    // wave end is only flagged on the last result of a sample
    a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("wave_done without final_result");

    // a non-final result means the second result is still in work
    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !s_tready)
        else $error("sample accepted while a result is still owed");

endmodule

bind waveform_interval_averager_unit wia_checker #(
    .DATA_W (M_DATA_W)
) u_wia_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/waveform_interval_averager_unit_tb.sv @@
// waveform_interval_averager_unit_tb: self-checking bench for the boxcar average decimator.
// Drives sample, result and register channels at random pace, predicts every result
// in-bench. Depends on wia_pkg and waveform_interval_averager_unit.
`timescale 1ns / 1ps

module waveform_interval_averager_unit_tb;

    import wia_pkg::*;

    localparam int IDX_W     = 20;
    localparam int FRAC_W    = 24;
    localparam int PHASE_W   = IDX_W + FRAC_W;
    localparam int SUM_W     = IDX_W + SAMPLE_W;
    localparam int COUNT_W   = IDX_W + 1;
    localparam int STEP_W    = FRAC_W + 1;
    localparam int M_DATA_W  = ((3 * IDX_W + VALUE_W + 7) / 8) * 8;
    localparam int CFG_W     = 32;
    // worst case: two averaged bins, each with multiply and divide, plus handoff slack
    localparam int SETTLE    = 240;
    localparam int N_SAMPLES = 1000;
    localparam int QUIET_AT  = 850;     // no idling past this many samples

    // tdata field offsets, lowest bits first
    localparam int VAL_LO   = IDX_W;
    localparam int FIRST_LO = IDX_W + VALUE_W;
    localparam int END_LO   = 2 * IDX_W + VALUE_W;

    typedef struct packed {
        logic [IDX_W-1:0]   bin_index;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   first_index;
        logic [IDX_W-1:0]   end_index;
        logic               final_result;
        logic               wave_done;
    } bin_result_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        cfg_reg_t              reg_sel;
        logic [CFG_W-1:0]      reg_value;
        logic [SAMPLE_W-1:0]   smp;
        logic                  eow;
        logic                  typed;     // expectation written in the table
        bin_result_t           want;
    } stim_row_t;

    // ---------------------------------------------------------------
    // DUT ports, all known from time zero
    // ---------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    waveform_interval_averager_unit #(
        .INDEX_BITS     (IDX_W),
        .STEP_FRAC_BITS (FRAC_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Bench-side copy of the block: registers and open-bin state
    // ---------------------------------------------------------------
    logic                 mode_points = 1'b0;
    logic [STEP_W-1:0]    step_q      = STEP_W'(1) << FRAC_W;
    logic [GAIN_W-1:0]    gain_q      = GAIN_RESET;
    logic [OFFSET_W-1:0]  offset_q    = '0;

    logic [IDX_W-1:0]     wave_pos    = '0;
    logic [PHASE_W-1:0]   phase_acc   = '0;
    logic [IDX_W-1:0]     open_bin    = '0;
    logic [IDX_W-1:0]     open_start  = '0;
    logic [SUM_W-1:0]     open_sum    = '0;
    logic [COUNT_W-1:0]   open_count  = '0;

    bin_result_t          pending_bins[$];   // in order of arrival
    bin_result_t          fresh_bins[$];     // results of the latest request
    int                   mismatch_count = 0;
    int                   samples_sent   = 0;
    logic                 idle_on        = 1'b1;
    logic                 use_typed      = 1'b0;
    bin_result_t          typed_want     = '0;
    int                   ready_hold     = 0;
    stim_row_t            directed_rows[$];

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Signed sum times gain, over count*2^16, truncated toward zero, plus offset.
    function automatic logic [VALUE_W-1:0] to_volts(input logic [SUM_W-1:0] sum,
                                                    input logic [COUNT_W-1:0] count);
        logic              neg;
        logic [SUM_W-1:0]  mag;
        logic [63:0]       prod;
        logic [63:0]       quot;
        logic [63:0]       res;
        neg  = sum[SUM_W-1];
        mag  = neg ? (SUM_W'(0) - sum) : sum;
        prod = 64'(mag) * 64'(gain_q[31:16]) + ((64'(mag) * 64'(gain_q[15:0])) >> 16);
        quot = (count != 0) ? prod / 64'(count) : 64'd0;
        res  = (neg ? (64'd0 - quot) : quot) + {{32{offset_q[31]}}, offset_q};
        return res[VALUE_W-1:0];
    endfunction

    // Advance the bin tracker by one sample and leave its results in fresh_bins.
    function automatic void predict_bins(input logic [SAMPLE_W-1:0] smp, input logic eow);
        logic [IDX_W-1:0]  n;
        logic [IDX_W-1:0]  bin;
        logic [IDX_W-1:0]  abin;
        logic              on_edge;
        logic              changed;
        logic [SUM_W-1:0]  sx;
        bin_result_t       r;
        n       = wave_pos;
        bin     = phase_acc[PHASE_W-1:FRAC_W];
        on_edge = (phase_acc[FRAC_W-1:0] == 0);
        sx      = {{(SUM_W-SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        // a closing sample right on a boundary belongs to the bin before it
        abin    = (eow && on_edge && bin != 0) ? bin - 1'b1 : bin;
        changed = (abin != open_bin);
        fresh_bins.delete();
        r = '0;
        if (!mode_points) begin
            if (changed) begin
                r.bin_index   = open_bin;
                r.value       = to_volts(open_sum, open_count);
                r.first_index = open_start;
                r.end_index   = n - 1'b1;
                fresh_bins.push_back(r);
            end
        end else if (n == 0 || bin != open_bin) begin
            r.bin_index   = bin;
            r.value       = to_volts(sx, COUNT_W'(1));
            r.first_index = n;
            r.end_index   = n;
            fresh_bins.push_back(r);
        end
        if (changed) begin
            open_bin   = abin;
            open_start = n;
            open_sum   = sx;
            open_count = COUNT_W'(1);
        end else begin
            open_sum   = open_sum + sx;
            open_count = open_count + 1'b1;
        end
        if (eow) begin
            if (!mode_points) begin
                r.bin_index   = open_bin;
                r.value       = to_volts(open_sum, open_count);
                r.first_index = open_start;
                r.end_index   = n;
                fresh_bins.push_back(r);
            end else if (!on_edge) begin
                // extra point past the last boundary
                r.bin_index   = bin + 1'b1;
                r.value       = to_volts(sx, COUNT_W'(1));
                r.first_index = n;
                r.end_index   = n;
                fresh_bins.push_back(r);
            end
        end
        if (fresh_bins.size() > 0) begin
            fresh_bins[fresh_bins.size()-1].final_result = 1'b1;
            fresh_bins[fresh_bins.size()-1].wave_done    = eow;
        end
        if (eow) begin
            wave_pos   = '0;
            phase_acc  = '0;
            open_bin   = '0;
            open_start = '0;
            open_sum   = '0;
            open_count = '0;
        end else begin
            wave_pos  = n + 1'b1;
            phase_acc = phase_acc + PHASE_W'(step_q);
        end
    endfunction

    // ---------------------------------------------------------------
    // Monitor: results checked first, then register writes mirrored and new requests predicted
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        bin_result_t got;
        bin_result_t want;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                got.bin_index    = m_tdata[IDX_W-1:0];
                got.value        = m_tdata[VAL_LO +: VALUE_W];
                got.first_index  = m_tdata[FIRST_LO +: IDX_W];
                got.end_index    = m_tdata[END_LO +: IDX_W];
                got.final_result = m_tuser;
                got.wave_done    = m_tlast;
                if (pending_bins.size() == 0) begin
                    report_mismatch($sformatf("unexpected result bin %0d value %h",
                                              got.bin_index, got.value));
                end else begin
                    want = pending_bins.pop_front();
                    if (got.bin_index !== want.bin_index)
                        report_mismatch($sformatf("bin_index %0d, expected %0d",
                                                  got.bin_index, want.bin_index));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value %h, expected %h (bin %0d)",
                                                  got.value, want.value, want.bin_index));
                    if (got.first_index !== want.first_index)
                        report_mismatch($sformatf("first_index %0d, expected %0d",
                                                  got.first_index, want.first_index));
                    if (got.end_index !== want.end_index)
                        report_mismatch($sformatf("end_index %0d, expected %0d",
                                                  got.end_index, want.end_index));
                    if (got.final_result !== want.final_result)
                        report_mismatch($sformatf("final_result %b, expected %b",
                                                  got.final_result, want.final_result));
                    if (got.wave_done !== want.wave_done)
                        report_mismatch($sformatf("wave_done %b, expected %b",
                                                  got.wave_done, want.wave_done));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_MODE:   mode_points = cfg_data[0];
                    REG_STEP:   step_q      = cfg_data[STEP_W-1:0];
                    REG_GAIN:   gain_q      = cfg_data[GAIN_W-1:0];
                    REG_OFFSET: offset_q    = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_bins(s_tdata, s_tlast);
                if (use_typed)
                    pending_bins.push_back(typed_want);
                else
                    foreach (fresh_bins[i]) pending_bins.push_back(fresh_bins[i]);
            end
        end
    end

    // Result sink: random back-pressure bursts
    always @(negedge clk) begin
        if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(0, 12);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Request drivers, all called at a falling edge
    // ---------------------------------------------------------------
    // Leaves s_tvalid high after the handshake so back-to-back requests
    // never lower and raise it in the same step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic eow,
                               input logic typed, input bin_result_t want);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        use_typed  = typed;
        typed_want = want;
        s_tvalid  <= 1'b1;
        s_tdata   <= smp;
        s_tlast   <= eow;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        use_typed = 1'b0;
        samples_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Block idle: nothing owed, and time for a sample that raised no result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_bins.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    function automatic void add_write(input cfg_reg_t sel, input logic [CFG_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind      = ROW_WRITE;
        row.reg_sel   = sel;
        row.reg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [SAMPLE_W-1:0] smp, input logic eow,
                                       input logic typed, input bin_result_t want);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_SAMPLE;
        row.smp   = smp;
        row.eow   = eow;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'h01FF_FFFF;                      // largest step, above one
            3:       return 32'(STEP_W'($urandom));             // anything the register holds
            4:       return 32'($urandom_range(1, 1 << FRAC_W));
            default: return 32'((1 << FRAC_W) >> $urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_word(input logic [CFG_W-1:0] usual);
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return usual;
            default: return $urandom;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        bin_result_t want;
        int          wave_left;
        int          phase_len;
        want      = '0;
        wave_left = 0;

        // single-sample waves after reset: value = sample, since gain is one count
        want = '{bin_index: '0, value: 48'd32767, first_index: '0, end_index: '0,
                 final_result: 1'b1, wave_done: 1'b1};
        add_sample(16'h7FFF, 1'b1, 1'b1, want);
        want.value = 48'hFFFF_FFFF_8000;
        add_sample(16'h8000, 1'b1, 1'b1, want);
        // unit step, full gain, top offset: the closing sample sits on a boundary
        add_write(REG_GAIN, 32'hFFFF_FFFF);
        add_write(REG_OFFSET, 32'h7FFF_FFFF);
        add_sample(16'h7FFF, 1'b0, 1'b0, '0);
        add_sample(16'h8000, 1'b0, 1'b0, '0);
        add_sample(16'h0001, 1'b0, 1'b0, '0);
        add_sample(16'h0000, 1'b1, 1'b0, '0);
        // points mode, half step: closing on a boundary, then off it (extra point)
        add_write(REG_MODE, 32'd1);
        add_write(REG_STEP, 32'h0080_0000);
        add_sample(16'h1234, 1'b0, 1'b0, '0);
        add_sample(16'h8000, 1'b0, 1'b0, '0);
        add_sample(16'h7FFF, 1'b1, 1'b0, '0);
        add_sample(16'h0001, 1'b0, 1'b0, '0);
        add_sample(16'hFFFF, 1'b1, 1'b0, '0);
        // zero step in points mode: the closing sample raises nothing
        add_write(REG_STEP, 32'd0);
        add_sample(16'h4000, 1'b0, 1'b0, '0);
        add_sample(16'h7FFF, 1'b0, 1'b0, '0);
        add_sample(16'h8000, 1'b1, 1'b0, '0);
        // averaging, step above one, zero gain, bottom offset
        add_write(REG_MODE, 32'd0);
        add_write(REG_STEP, 32'h01FF_FFFF);
        add_write(REG_GAIN, 32'd0);
        add_write(REG_OFFSET, 32'h8000_0000);
        add_sample(16'h5555, 1'b0, 1'b0, '0);
        add_sample(16'hAAAA, 1'b0, 1'b0, '0);
        add_sample(16'h0000, 1'b1, 1'b0, '0);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].reg_value);
            end else begin
                send_sample(directed_rows[i].smp, directed_rows[i].eow,
                            directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases. Waveforms run across phase boundaries, so register
        // changes (mode too) also land in the middle of a waveform.
        samples_sent = 0;
        while (samples_sent < N_SAMPLES) begin
            wait_idle();
            if ($urandom_range(0, 1)) write_reg(REG_MODE, 32'($urandom_range(0, 1)));
            if ($urandom_range(0, 1)) write_reg(REG_STEP, pick_step());
            if ($urandom_range(0, 2) == 0) write_reg(REG_GAIN, pick_word(32'h0001_0000));
            if ($urandom_range(0, 2) == 0) write_reg(REG_OFFSET, pick_word(32'h0000_0000));
            idle_on   = (samples_sent < QUIET_AT) && ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(5, 40);
            repeat (phase_len) begin
                if (wave_left == 0)
                    wave_left = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
                                                            : $urandom_range(1, 24);
                wave_left--;
                if (samples_sent >= QUIET_AT) idle_on = 1'b0;
                send_sample(pick_sample(), wave_left == 0, 1'b0, '0);
            end
        end

        wait_idle();
        foreach (pending_bins[i])
            report_mismatch($sformatf("result for bin %0d never came", pending_bins[i].bin_index));
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
